// File: rtl/pkcs7_pkg.sv
// Shared types and constants for the PKCS#7 pad/unpad stream block.
// Defines payload structs, error codes and controller states; no dependencies.
package pkcs7_pkg;

  localparam int BLOCK_BYTES_DEF = 16;

  typedef enum logic [2:0] {
    ERR_OK           = 3'd0,
    ERR_EMPTY        = 3'd1,
    ERR_LENGTH       = 3'd2,
    ERR_PAD_VALUE    = 3'd3,
    ERR_PAD_MISMATCH = 3'd4
  } err_code_t;

  typedef struct packed {
    logic       byte_present;
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic       out_present;
    logic [7:0] out_byte;
    logic       out_last;
    logic [2:0] error_code;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVICT,
    S_PAD_FILL,
    S_CHECK,
    S_PADVAL,
    S_VERIFY,
    S_KEEP,
    S_FINAL
  } state_t;

endpackage

// File: rtl/pkcs7_pad_unpad_stream.sv
// Top level of the PKCS#7 padder/unpadder: controller, output register and hold buffer.
// Depends on pkcs7_pkg and pkcs7_ram (circular hold buffer of BLOCK_BYTES entries).
//
//   port group   direction  handshake           payload
//   in_*         input      in_valid/in_stall   in_data  (in_item_t)
//   out_*        output     out_valid/out_stall out_data (out_item_t)
//   cfg_*        input      cfg_we              cfg_wdata (unpad_mode)
//
// Pad mode: one byte item per cycle while the output is free; end of message stalls input
// while n pad bytes of value n go out. Unpad mode: one byte per cycle while the buffer
// fills and the output is free; once full, S_IDLE reads the oldest entry and S_EVICT
// sends it and writes back on the single RAM port pair. End check in unpad mode: S_CHECK
// routes an empty message or length error to S_FINAL; else S_PADVAL reads the pad value,
// S_VERIFY checks pad bytes; S_KEEP sends kept bytes, or S_FINAL an error or bare last
// marker. Synchronous reset clears control state; the hold buffer needs no clearing pass.
// An output stall holds the output register and the states that load it; others advance.
module pkcs7_pad_unpad_stream
  import pkcs7_pkg::*;
#(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  localparam int IDX_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int CNT_W = $clog2(BLOCK_BYTES + 1);
  localparam logic [IDX_W:0]   BLK_SUM  = (IDX_W + 1)'(BLOCK_BYTES);
  localparam logic [CNT_W-1:0] BLK_CNT  = CNT_W'(BLOCK_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_BYTES - 1);
  localparam logic [7:0]       BLK_BYTE = 8'(BLOCK_BYTES);

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= BLK_SUM) begin
      s = s - BLK_SUM;
    end
    return s[IDX_W-1:0];
  endfunction

  state_t           state, state_next;
  logic             unpad_mode, unpad_mode_next;
  logic [IDX_W-1:0] head, head_next;
  logic [CNT_W-1:0] hold_count, hold_count_next;
  logic [IDX_W-1:0] len_mod, len_mod_next;
  logic             seen_any, seen_any_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] keep_cnt, keep_cnt_next;
  logic [7:0]       pad_n, pad_n_next;
  logic [CNT_W-1:0] pad_left, pad_left_next;
  logic [7:0]       held_byte, held_byte_next;
  logic             held_eom, held_eom_next;
  err_code_t        err, err_next;

  logic             out_free;
  logic             out_load;
  out_item_t        out_next;
  logic [IDX_W-1:0] len_inc;
  logic [IDX_W-1:0] len_after;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  pkcs7_ram #(
    .WIDTH(8),
    .DEPTH(BLOCK_BYTES)
  ) u_hold_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_free  = !out_valid || !out_stall;
  assign len_inc   = (len_mod == LAST_IDX) ? '0 : len_mod + IDX_W'(1);
  assign len_after = in_data.byte_present ? len_inc : len_mod;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      unpad_mode <= 1'b0;
      head       <= '0;
      hold_count <= '0;
      len_mod    <= '0;
      seen_any   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      unpad_mode <= unpad_mode_next;
      head       <= head_next;
      hold_count <= hold_count_next;
      len_mod    <= len_mod_next;
      seen_any   <= seen_any_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    keep_cnt  <= keep_cnt_next;
    pad_n     <= pad_n_next;
    pad_left  <= pad_left_next;
    held_byte <= held_byte_next;
    held_eom  <= held_eom_next;
    err       <= err_next;
    if (out_load) begin
      out_data <= out_next;
    end
  end

  always_comb begin
    state_next      = state;
    unpad_mode_next = unpad_mode;
    head_next       = head;
    hold_count_next = hold_count;
    len_mod_next    = len_mod;
    seen_any_next   = seen_any;
    idx_next        = idx;
    keep_cnt_next   = keep_cnt;
    pad_n_next      = pad_n;
    pad_left_next   = pad_left;
    held_byte_next  = held_byte;
    held_eom_next   = held_eom;
    err_next        = err;
    in_stall        = 1'b1;
    out_load        = 1'b0;
    out_next        = '0;
    ram_we          = 1'b0;
    ram_waddr       = head;
    ram_wdata       = held_byte;
    ram_re          = 1'b0;
    ram_raddr       = head;

    unique case (state)
      S_IDLE: begin
        in_stall = !out_free;
        if (in_valid && out_free) begin
          held_byte_next = in_data.data_byte;
          held_eom_next  = in_data.end_of_message;
          if (!unpad_mode) begin
            if (in_data.byte_present) begin
              out_load      = 1'b1;
              out_next      = '{1'b1, in_data.data_byte, 1'b0, ERR_OK};
              len_mod_next  = len_inc;
              seen_any_next = 1'b1;
            end
            if (in_data.end_of_message) begin
              pad_left_next = BLK_CNT - CNT_W'(len_after);
              pad_n_next    = BLK_BYTE - 8'(len_after);
              len_mod_next  = '0;
              seen_any_next = 1'b0;
              state_next    = S_PAD_FILL;
            end
          end else if (in_data.byte_present) begin
            if (hold_count == BLK_CNT) begin
              // buffer full: fetch the oldest byte before overwriting its entry
              ram_re     = 1'b1;
              ram_raddr  = head;
              state_next = S_EVICT;
            end else begin
              ram_we          = 1'b1;
              ram_waddr       = wrap_add(head, hold_count[IDX_W-1:0]);
              ram_wdata       = in_data.data_byte;
              hold_count_next = hold_count + CNT_W'(1);
              len_mod_next    = len_inc;
              seen_any_next   = 1'b1;
              if (in_data.end_of_message) begin
                state_next = S_CHECK;
              end
            end
          end else if (in_data.end_of_message) begin
            state_next = S_CHECK;
          end
        end
      end

      S_EVICT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_next      = '{1'b1, ram_rdata, 1'b0, ERR_OK};
          ram_we        = 1'b1;
          ram_waddr     = head;
          ram_wdata     = held_byte;
          head_next     = wrap_add(head, IDX_W'(1));
          len_mod_next  = len_inc;
          seen_any_next = 1'b1;
          state_next    = held_eom ? S_CHECK : S_IDLE;
        end
      end

      S_PAD_FILL: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_next      = '{1'b1, pad_n, pad_left == CNT_W'(1), ERR_OK};
          pad_left_next = pad_left - CNT_W'(1);
          if (pad_left == CNT_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end

      S_CHECK: begin
        if (!seen_any) begin
          err_next   = ERR_EMPTY;
          state_next = S_FINAL;
        end else if (len_mod != '0 || hold_count != BLK_CNT) begin
          err_next   = ERR_LENGTH;
          state_next = S_FINAL;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = wrap_add(head, LAST_IDX);
          state_next = S_PADVAL;
        end
      end

      S_PADVAL: begin
        if (ram_rdata == 8'd0 || ram_rdata > BLK_BYTE) begin
          err_next   = ERR_PAD_VALUE;
          state_next = S_FINAL;
        end else begin
          pad_n_next    = ram_rdata;
          idx_next      = IDX_W'(BLK_CNT - ram_rdata[CNT_W-1:0]);
          keep_cnt_next = IDX_W'(BLK_CNT - ram_rdata[CNT_W-1:0]);
          ram_re        = 1'b1;
          ram_raddr     = wrap_add(head, IDX_W'(BLK_CNT - ram_rdata[CNT_W-1:0]));
          state_next    = S_VERIFY;
        end
      end

      S_VERIFY: begin
        if (ram_rdata != pad_n) begin
          err_next   = ERR_PAD_MISMATCH;
          state_next = S_FINAL;
        end else if (idx == LAST_IDX) begin
          if (keep_cnt == '0) begin
            // whole block was padding: a bare last marker
            err_next   = ERR_OK;
            state_next = S_FINAL;
          end else begin
            idx_next   = '0;
            ram_re     = 1'b1;
            ram_raddr  = head;
            state_next = S_KEEP;
          end
        end else begin
          idx_next  = idx + IDX_W'(1);
          ram_re    = 1'b1;
          ram_raddr = wrap_add(head, idx + IDX_W'(1));
        end
      end

      S_KEEP: begin
        if (out_free) begin
          out_load = 1'b1;
          out_next = '{1'b1, ram_rdata, idx == keep_cnt - IDX_W'(1), ERR_OK};
          if (idx == keep_cnt - IDX_W'(1)) begin
            hold_count_next = '0;
            len_mod_next    = '0;
            seen_any_next   = 1'b0;
            state_next      = S_IDLE;
          end else begin
            idx_next  = idx + IDX_W'(1);
            ram_re    = 1'b1;
            ram_raddr = wrap_add(head, idx + IDX_W'(1));
          end
        end
      end

      S_FINAL: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_next        = '{1'b0, 8'd0, 1'b1, err};
          hold_count_next = '0;
          len_mod_next    = '0;
          seen_any_next   = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // a mode change drops the message in progress
    if (cfg_we) begin
      unpad_mode_next = cfg_wdata;
      hold_count_next = '0;
      len_mod_next    = '0;
      seen_any_next   = 1'b0;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    hold_count <= BLK_CNT)
    else $error("hold count exceeds block size");

  a_pad_no_ram : assert property (@(posedge clk) disable iff (rst)
    !unpad_mode |-> !ram_we)
    else $error("hold buffer written in pad mode");

  a_last_to_idle : assert property (@(posedge clk) disable iff (rst)
    (out_load && out_next.out_last) |=> state == S_IDLE)
    else $error("controller busy after last result of a message");

  a_error_shape : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.error_code != ERR_OK) |-> (!out_data.out_present && out_data.out_last))
    else $error("error result carries a byte or is not last");

endmodule

// File: rtl/pkcs7_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read data holds while read enable is low. No package dependencies.
module pkcs7_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sim/tb_pkcs7_pad_unpad_stream.sv
// Self-checking testbench for pkcs7_pad_unpad_stream: a directed table, then random messages.
// A local PKCS#7 predictor builds the expected transfers. Depends on pkcs7_pkg and the RTL.
module tb_pkcs7_pad_unpad_stream;
  import pkcs7_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLK = BLOCK_BYTES_DEF;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    bit        mode;
    in_item_t  item;
    int        rep;
    bit        typed;
    out_item_t fixed;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  // predictor state
  logic [7:0] held [BLK];
  int         held_cnt;
  int         len_mod;
  bit         any_byte;
  bit         strip_mode;

  out_item_t  expected_q [$];
  out_item_t  step_q [$];
  out_item_t  want;
  int         failures = 0;
  int         cycle_count = 0;
  int         gap_pct = 0;
  int         stall_pct = 0;
  int         phase_items;

  dir_row_t dir_rows [9] = '{
    '{1'b0, in_item_t'{1'b1, 8'h00, 1'b0}, 1, 1'b1, out_item_t'{1'b1, 8'h00, 1'b0, ERR_OK}},
    '{1'b0, in_item_t'{1'b1, 8'hFF, 1'b0}, 1, 1'b1, out_item_t'{1'b1, 8'hFF, 1'b0, ERR_OK}},
    '{1'b0, in_item_t'{1'b0, 8'h00, 1'b0}, 1, 1'b0, out_item_t'('0)},
    '{1'b0, in_item_t'{1'b1, 8'hA5, 1'b1}, 1, 1'b0, out_item_t'('0)},
    '{1'b0, in_item_t'{1'b0, 8'hFF, 1'b1}, 1, 1'b0, out_item_t'('0)},
    '{1'b1, in_item_t'{1'b0, 8'h00, 1'b1}, 1, 1'b1,
      out_item_t'{1'b0, 8'h00, 1'b1, ERR_EMPTY}},
    '{1'b1, in_item_t'{1'b1, 8'h7E, 1'b1}, 1, 1'b1,
      out_item_t'{1'b0, 8'h00, 1'b1, ERR_LENGTH}},
    '{1'b1, in_item_t'{1'b1, 8'h5A, 1'b0}, 15, 1'b0, out_item_t'('0)},
    '{1'b1, in_item_t'{1'b1, 8'h00, 1'b1}, 1, 1'b1,
      out_item_t'{1'b0, 8'h00, 1'b1, ERR_PAD_VALUE}}
  };

  pkcs7_pad_unpad_stream DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic out_item_t make_out(logic p, logic [7:0] b, logic l, err_code_t e);
    out_item_t r;
    r.out_present = p;
    r.out_byte    = b;
    r.out_last    = l;
    r.error_code  = e;
    return r;
  endfunction

  function automatic string show(out_item_t r);
    return $sformatf("present=%0d byte=%02h last=%0d err=%0d",
                     r.out_present, r.out_byte, r.out_last, r.error_code);
  endfunction

  function void clear_message();
    held_cnt = 0;
    len_mod  = 0;
    any_byte = 1'b0;
  endfunction

  // Fill step_q with the transfers one input item causes.
  function void pkcs7_predict(in_item_t it);
    int        n;
    int        keep;
    err_code_t err;
    step_q.delete();
    if (!strip_mode) begin
      if (it.byte_present) begin
        step_q.push_back(make_out(1'b1, it.data_byte, 1'b0, ERR_OK));
        len_mod  = (len_mod + 1) % BLK;
        any_byte = 1'b1;
      end
      if (it.end_of_message) begin
        n = BLK - len_mod;
        for (int i = 0; i < n; i++)
          step_q.push_back(make_out(1'b1, 8'(n), i == n - 1, ERR_OK));
        clear_message();
      end
    end else begin
      if (it.byte_present) begin
        // evict the oldest byte once the delay buffer is full
        if (held_cnt >= BLK) begin
          step_q.push_back(make_out(1'b1, held[0], 1'b0, ERR_OK));
          for (int i = 0; i < BLK - 1; i++)
            held[i] = held[i + 1];
          held_cnt = BLK - 1;
        end
        held[held_cnt] = it.data_byte;
        held_cnt++;
        len_mod  = (len_mod + 1) % BLK;
        any_byte = 1'b1;
      end
      if (it.end_of_message) begin
        n = 0;
        if (!any_byte)
          err = ERR_EMPTY;
        else if (len_mod != 0 || held_cnt != BLK)
          err = ERR_LENGTH;
        else begin
          n = held[BLK - 1];
          if (n < 1 || n > BLK)
            err = ERR_PAD_VALUE;
          else begin
            err = ERR_OK;
            for (int i = BLK - n; i < BLK; i++)
              if (held[i] != n) err = ERR_PAD_MISMATCH;
          end
        end
        if (err != ERR_OK)
          step_q.push_back(make_out(1'b0, 8'h00, 1'b1, err));
        else begin
          keep = BLK - n;
          if (keep == 0) step_q.push_back(make_out(1'b0, 8'h00, 1'b1, ERR_OK));
          for (int i = 0; i < keep; i++)
            step_q.push_back(make_out(1'b1, held[i], i == keep - 1, ERR_OK));
        end
        clear_message();
      end
    end
  endfunction

  task automatic wait_idle();
    // drop valid first so the last item is not taken again
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    strip_mode = m;
    clear_message();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(in_item_t it, bit typed, out_item_t fixed);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pkcs7_predict(it);
    if (typed)
      expected_q.push_back(fixed);
    else
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    if (it.byte_present || it.end_of_message) phase_items++;
  endtask

  // Send one message; stray empty items land between bytes now and then.
  task automatic send_message(logic [7:0] msg [$], bit eom_alone);
    in_item_t it;
    for (int i = 0; i < msg.size(); i++) begin
      if ($urandom_range(99) < 5) begin
        it = '{1'b0, 8'($urandom), 1'b0};
        send_item(it, 1'b0, '0);
      end
      it = '{1'b1, msg[i], !eom_alone && i == msg.size() - 1};
      send_item(it, 1'b0, '0);
    end
    if (eom_alone || msg.size() == 0) begin
      it = '{1'b0, 8'($urandom), 1'b1};
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic random_message();
    logic [7:0] msg [$];
    int         kind;
    int         len;
    int         n;
    int         total;
    int         pick;
    if (!strip_mode) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(14, 17) : $urandom_range(0, 5);
      for (int i = 0; i < len; i++) msg.push_back(8'($urandom));
    end else begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        total = ($urandom_range(3) == 0) ? 2 * BLK : BLK;
        pick  = $urandom_range(9);
        if (kind >= 70) n = $urandom_range(2, BLK);
        else if (pick == 0) n = 1;
        else if (pick == 1) n = BLK;
        else n = $urandom_range(1, BLK);
        for (int i = 0; i < total - n; i++) msg.push_back(8'($urandom));
        for (int i = 0; i < n; i++) msg.push_back(8'(n));
        // break one pad byte other than the last
        if (kind >= 70) msg[$urandom_range(total - n, total - 2)] ^= 8'($urandom_range(1, 255));
      end else if (kind < 90) begin
        for (int i = 0; i < BLK - 1; i++) msg.push_back(8'($urandom));
        msg.push_back($urandom_range(1) ? 8'h00 : 8'($urandom_range(BLK + 1, 255)));
      end else begin
        len = $urandom_range(0, BLK + 4);
        for (int i = 0; i < len; i++) msg.push_back(8'($urandom));
      end
    end
    send_message(msg, $urandom_range(4) == 0);
  endtask

  // receiver side: random stall, changed at the falling edge
  always @(negedge clk) begin
    if (rst)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %s", $time, show(out_data));
        failures++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.out_present !== want.out_present || out_data.out_byte !== want.out_byte ||
            out_data.out_last !== want.out_last || out_data.error_code !== want.error_code) begin
          $display("%0t: mismatch, expected %s, actual %s", $time, show(want), show(out_data));
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    strip_mode = 1'b0;
    clear_message();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].mode != strip_mode) write_mode(dir_rows[r].mode);
      repeat (dir_rows[r].rep) send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].fixed);
    end

    // random phases: none, sender gaps, receiver stalls, both
    for (int p = 0; p < 4; p++) begin
      for (int m = 0; m < 2; m++) begin
        gap_pct   = (p == 1) ? 79 : (p == 3) ? 27 : 0;
        stall_pct = (p == 2) ? 79 : (p == 3) ? 27 : 0;
        write_mode(m[0]);
        phase_items = 0;
        while (phase_items < (m == 0 ? 15 : 25)) random_message();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_idle();
    if (failures == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
